// ===== design/trsa_pkg.sv =====
// Shared constants, command codes and control/status types for the toy RSA block
`default_nettype none
package trsa_pkg;

    localparam int MESSAGE_BYTES_DEF = 5;
    localparam int HASH_STEP         = 13;
    localparam int PUB_EXP           = 17;
    localparam int W_N               = 25;   // modulus, phi, residues
    localparam int W_X               = 13;   // prime candidate
    localparam int W_K               = 7;    // trial divisor
    localparam int W_KSQ             = 14;   // square of trial divisor
    localparam int W_T               = 27;   // signed Euclid coefficients
    localparam int W_PROD            = 50;   // full product
    localparam int W_CNT             = 6;    // divider step count
    localparam int W_OP              = 5;

    // Divider step counts for each operand pair
    localparam logic [W_CNT-1:0] DIV_BITS_X    = 6'd13;
    localparam logic [W_CNT-1:0] DIV_BITS_EUC  = 6'd25;
    localparam logic [W_CNT-1:0] DIV_BITS_HASH = 6'd24;
    localparam logic [W_CNT-1:0] DIV_BITS_PROD = 6'd50;

    // Configuration register indexes
    localparam logic REG_PRIVATE_KEY = 1'b0;
    localparam logic REG_HASH_SEED   = 1'b1;

    // Operation codes of the input transaction
    localparam logic CMD_SIGN   = 1'b0;
    localparam logic CMD_VERIFY = 1'b1;

    // Datapath commands
    localparam logic [W_OP-1:0] OP_NONE     = 5'd0;
    localparam logic [W_OP-1:0] OP_LOAD     = 5'd1;
    localparam logic [W_OP-1:0] OP_HASH     = 5'd2;
    localparam logic [W_OP-1:0] OP_XSEED_P  = 5'd3;
    localparam logic [W_OP-1:0] OP_XSEED_Q  = 5'd4;
    localparam logic [W_OP-1:0] OP_DIV_XK   = 5'd5;
    localparam logic [W_OP-1:0] OP_KNEXT    = 5'd6;
    localparam logic [W_OP-1:0] OP_XNEXT    = 5'd7;
    localparam logic [W_OP-1:0] OP_SETP     = 5'd8;
    localparam logic [W_OP-1:0] OP_SETQ     = 5'd9;
    localparam logic [W_OP-1:0] OP_MUL_N    = 5'd10;
    localparam logic [W_OP-1:0] OP_EUC_INIT = 5'd11;
    localparam logic [W_OP-1:0] OP_DIV_EUC  = 5'd12;
    localparam logic [W_OP-1:0] OP_EUC_MUL  = 5'd13;
    localparam logic [W_OP-1:0] OP_EUC_UPD  = 5'd14;
    localparam logic [W_OP-1:0] OP_D_FIN    = 5'd15;
    localparam logic [W_OP-1:0] OP_DIV_HM   = 5'd16;
    localparam logic [W_OP-1:0] OP_SET_HMOD = 5'd17;
    localparam logic [W_OP-1:0] OP_DIV_SIG  = 5'd18;
    localparam logic [W_OP-1:0] OP_POW_INIT = 5'd19;
    localparam logic [W_OP-1:0] OP_MUL_AB   = 5'd20;
    localparam logic [W_OP-1:0] OP_MUL_BB   = 5'd21;
    localparam logic [W_OP-1:0] OP_DIV_PROD = 5'd22;
    localparam logic [W_OP-1:0] OP_SET_ACC  = 5'd23;
    localparam logic [W_OP-1:0] OP_SET_BASE = 5'd24;
    localparam logic [W_OP-1:0] OP_RESULT   = 5'd25;

    typedef struct packed {
        logic [W_OP-1:0] op;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic rem_zero;
        logic ksq_gt_x;
        logic nr_zero;
        logic e_zero;
        logic e_lsb;
        logic hash_last;
        logic is_verify;
        logic m_zero;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== design/trsa_ifs.sv =====
// Valid/ready channel interfaces: input items, results and configuration writes
`default_nettype none
interface trsa_in_if #(parameter int MSG_W = 8 * trsa_pkg::MESSAGE_BYTES_DEF);
    logic             valid;
    logic             ready;
    logic             cmd;
    logic [MSG_W-1:0] message;
    logic [23:0]      modulus;
    logic [23:0]      signature;
    modport source (output valid, cmd, message, modulus, signature, input ready);
    modport sink   (input valid, cmd, message, modulus, signature, output ready);
endinterface

interface trsa_out_if;
    logic        valid;
    logic        ready;
    logic [23:0] signature_out;
    logic [23:0] modulus_out;
    logic [23:0] hash_out;
    logic        valid_res;
    modport source (output valid, signature_out, modulus_out, hash_out, valid_res,
                    input ready);
    modport sink   (input valid, signature_out, modulus_out, hash_out, valid_res,
                    output ready);
endinterface

interface trsa_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/trsa_div.sv =====
// Restoring divider, one quotient bit per cycle, for a selectable dividend length
`default_nettype none
module trsa_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [trsa_pkg::W_PROD-1:0]   i_dvd,
    input  wire logic [trsa_pkg::W_N-1:0]      i_dvs,
    input  wire logic [trsa_pkg::W_CNT-1:0]    i_bits,
    output logic                               o_busy,
    output logic [trsa_pkg::W_N-1:0]           o_quo,
    output logic [trsa_pkg::W_N-1:0]           o_rem
);
    logic [trsa_pkg::W_PROD-1:0] r_dvd;
    logic [trsa_pkg::W_N-1:0]    r_dvs;
    logic [trsa_pkg::W_CNT-1:0]  r_cnt;
    logic [trsa_pkg::W_N-1:0]    r_quo;
    logic [trsa_pkg::W_N-1:0]    r_rem;
    logic                        r_busy;
    logic [trsa_pkg::W_CNT-1:0]  w_idx;
    logic [trsa_pkg::W_N:0]      w_trial;
    logic                        w_ge;

    // Shift the next dividend bit into the partial remainder and try a subtract
    assign w_idx   = r_cnt - 1'b1;
    assign w_trial = {r_rem, r_dvd[w_idx]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_cnt == 1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dvd;
            r_dvs <= i_dvs;
            r_cnt <= i_bits;
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            r_quo <= {r_quo[trsa_pkg::W_N-2:0], w_ge};
            r_rem <= w_ge ? trsa_pkg::W_N'(w_trial - {1'b0, r_dvs})
                          : w_trial[trsa_pkg::W_N-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != 0))
        else $error("divider busy with no steps left");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && (i_bits > 1)) |=> r_busy)
        else $error("divider did not start");
`endif
endmodule
`default_nettype wire

// ===== design/trsa_dp.sv =====
// Datapath: hash, prime search, Euclid inverse, modular exponentiation and result register
`default_nettype none
module trsa_dp #(
    parameter int MESSAGE_BYTES = trsa_pkg::MESSAGE_BYTES_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire trsa_pkg::t_cmd               i_cmd,
    output trsa_pkg::t_sts                    o_sts,
    input  wire logic                         i_in_cmd,
    input  wire logic [8*MESSAGE_BYTES-1:0]   i_in_message,
    input  wire logic [23:0]                  i_in_modulus,
    input  wire logic [23:0]                  i_in_signature,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic [23:0]                  i_cfg_data,
    input  wire logic                         i_out_ready,
    output logic                              o_out_valid,
    output logic [23:0]                       o_signature_out,
    output logic [23:0]                       o_modulus_out,
    output logic [23:0]                       o_hash_out,
    output logic                              o_valid_res
);
    localparam int MSG_W  = 8 * MESSAGE_BYTES;
    localparam int BUF_W  = MSG_W + 24;
    localparam int NBYTES = MESSAGE_BYTES + 3;
    localparam int HI_W   = $clog2(NBYTES);
    localparam int WN     = trsa_pkg::W_N;
    localparam int WT     = trsa_pkg::W_T;

    logic [15:0]               r_key;
    logic [23:0]               r_seed;
    logic                      r_cmdv;
    logic [MSG_W-1:0]          r_msg;
    logic [23:0]               r_ext;
    logic [23:0]               r_sig;
    logic [31:0]               r_h;
    logic [HI_W-1:0]           r_hi;
    logic [HI_W-1:0]           r_hlast;
    logic [trsa_pkg::W_X-1:0]  r_x;
    logic [trsa_pkg::W_K-1:0]  r_k;
    logic [trsa_pkg::W_KSQ-1:0] r_ksq;
    logic [trsa_pkg::W_X-1:0]  r_p;
    logic [trsa_pkg::W_X-1:0]  r_q;
    logic [WN-1:0]             r_m;
    logic [WN-1:0]             r_phi;
    logic signed [WT-1:0]      r_t;
    logic signed [WT-1:0]      r_nt;
    logic [WN-1:0]             r_r;
    logic [WN-1:0]             r_nr;
    logic [31:0]               r_d;
    logic [WN-1:0]             r_acc;
    logic [WN-1:0]             r_base;
    logic [31:0]               r_e;
    logic [WN-1:0]             r_hmod;
    logic [trsa_pkg::W_PROD-1:0] r_prod;
    logic                      r_out_valid;
    logic [23:0]               r_sig_out;
    logic [23:0]               r_mod_out;
    logic [23:0]               r_hash_out;
    logic                      r_valid_res;

    logic [BUF_W-1:0]          w_buf;
    logic [7:0]                w_byte;
    logic [31:0]               w_hx;
    logic                      w_div_start;
    logic [trsa_pkg::W_PROD-1:0] w_dvd;
    logic [WN-1:0]             w_dvs;
    logic [trsa_pkg::W_CNT-1:0] w_bits;
    logic                      w_busy;
    logic [WN-1:0]             w_quo;
    logic [WN-1:0]             w_rem;
    logic [WN-1:0]             w_ma;
    logic [WN-1:0]             w_mb;
    logic [WT-1:0]             w_nt_abs;
    logic signed [WT-1:0]      w_p27;
    logic signed [WT-1:0]      w_tfix;

    // Hash byte: message bytes first, then the key or modulus bytes
    assign w_buf  = {r_msg, r_ext};
    assign w_byte = w_buf[(BUF_W - 1) - 8 * r_hi -: 8];
    assign w_hx   = r_h ^ (32'(w_byte) + 32'(r_hi) * 32'(trsa_pkg::HASH_STEP));

    // Divider operand selection
    always_comb begin
        w_div_start = 1'b1;
        w_dvd       = 50'(r_prod);
        w_dvs       = r_m;
        w_bits      = trsa_pkg::DIV_BITS_PROD;
        unique case (i_cmd.op)
            trsa_pkg::OP_DIV_XK: begin
                w_dvd  = 50'(r_x);
                w_dvs  = WN'(r_k);
                w_bits = trsa_pkg::DIV_BITS_X;
            end
            trsa_pkg::OP_DIV_EUC: begin
                w_dvd  = 50'(r_r);
                w_dvs  = r_nr;
                w_bits = trsa_pkg::DIV_BITS_EUC;
            end
            trsa_pkg::OP_DIV_HM: begin
                w_dvd  = 50'(r_h[23:0]);
                w_bits = trsa_pkg::DIV_BITS_HASH;
            end
            trsa_pkg::OP_DIV_SIG: begin
                w_dvd  = 50'(r_sig);
                w_bits = trsa_pkg::DIV_BITS_HASH;
            end
            trsa_pkg::OP_DIV_PROD: begin
                w_dvd  = r_prod;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    trsa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_dvd   (w_dvd),
        .i_dvs   (w_dvs),
        .i_bits  (w_bits),
        .o_busy  (w_busy),
        .o_quo   (w_quo),
        .o_rem   (w_rem)
    );

    // Shared multiplier operands
    assign w_nt_abs = r_nt[WT-1] ? WT'(-r_nt) : WT'(r_nt);
    always_comb begin
        case (i_cmd.op)
            trsa_pkg::OP_MUL_AB:  begin w_ma = r_acc;  w_mb = r_base; end
            trsa_pkg::OP_EUC_MUL: begin w_ma = w_quo;  w_mb = w_nt_abs[WN-1:0]; end
            default:              begin w_ma = r_base; w_mb = r_base; end
        endcase
    end

    assign w_p27  = $signed(r_prod[WT-1:0]);
    assign w_tfix = r_t[WT-1] ? (r_t + $signed({2'b00, r_phi})) : r_t;

    // Configuration registers and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= '0;
            r_seed      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == trsa_pkg::REG_PRIVATE_KEY) begin
                    r_key <= i_cfg_data[15:0];
                end else begin
                    r_seed <= i_cfg_data;
                end
            end
            if (i_cmd.op == trsa_pkg::OP_RESULT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Execute datapath commands
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            trsa_pkg::OP_LOAD: begin
                r_cmdv <= i_in_cmd;
                r_msg  <= i_in_message;
                r_sig  <= i_in_signature;
                r_h    <= {8'h00, r_seed};
                r_hi   <= '0;
                if (i_in_cmd == trsa_pkg::CMD_VERIFY) begin
                    r_ext   <= i_in_modulus;
                    r_m     <= WN'(i_in_modulus);
                    r_hlast <= HI_W'(MESSAGE_BYTES + 2);
                end else begin
                    r_ext   <= {r_key, 8'h00};
                    r_hlast <= HI_W'(MESSAGE_BYTES + 1);
                end
            end
            trsa_pkg::OP_HASH: begin
                r_h  <= {w_hx[26:0], w_hx[31:27]};
                r_hi <= r_hi + 1'b1;
            end
            trsa_pkg::OP_XSEED_P: begin
                r_x   <= {2'b01, r_key[14:4]};
                r_k   <= 7'd2;
                r_ksq <= 14'd4;
            end
            trsa_pkg::OP_XSEED_Q: begin
                r_x   <= {2'b01, r_key[10:0]};
                r_k   <= 7'd2;
                r_ksq <= 14'd4;
            end
            trsa_pkg::OP_KNEXT: begin
                r_ksq <= r_ksq + {6'd0, r_k, 1'b1};
                r_k   <= r_k + 1'b1;
            end
            trsa_pkg::OP_XNEXT: begin
                r_x   <= r_x + 1'b1;
                r_k   <= 7'd2;
                r_ksq <= 14'd4;
            end
            trsa_pkg::OP_SETP: r_p <= r_x;
            trsa_pkg::OP_SETQ: r_q <= r_x;
            trsa_pkg::OP_MUL_N: begin
                r_m   <= WN'(26'(r_p) * 26'(r_q));
                r_phi <= WN'(26'(r_p - 1'b1) * 26'(r_q - 1'b1));
            end
            trsa_pkg::OP_EUC_INIT: begin
                r_t  <= '0;
                r_nt <= WT'(1);
                r_r  <= r_phi;
                r_nr <= WN'(trsa_pkg::PUB_EXP);
            end
            trsa_pkg::OP_EUC_MUL, trsa_pkg::OP_MUL_AB, trsa_pkg::OP_MUL_BB: begin
                r_prod <= {25'd0, w_ma} * {25'd0, w_mb};
            end
            trsa_pkg::OP_EUC_UPD: begin
                r_nt <= r_nt[WT-1] ? (r_t + w_p27) : (r_t - w_p27);
                r_t  <= r_nt;
                r_r  <= r_nr;
                r_nr <= w_rem;
            end
            trsa_pkg::OP_D_FIN: begin
                r_d <= (r_r > WN'(1)) ? 32'hFFFF_FFFF : {5'd0, w_tfix};
            end
            trsa_pkg::OP_SET_HMOD: r_hmod <= w_rem;
            trsa_pkg::OP_POW_INIT: begin
                r_base <= w_rem;
                r_acc  <= (r_m == WN'(1)) ? '0 : WN'(1);
                r_e    <= (r_cmdv == trsa_pkg::CMD_VERIFY) ? 32'(trsa_pkg::PUB_EXP) : r_d;
            end
            trsa_pkg::OP_SET_ACC: r_acc <= w_rem;
            trsa_pkg::OP_SET_BASE: begin
                r_base <= w_rem;
                r_e    <= {1'b0, r_e[31:1]};
            end
            trsa_pkg::OP_RESULT: begin
                if (r_cmdv == trsa_pkg::CMD_VERIFY) begin
                    r_sig_out   <= '0;
                    r_mod_out   <= '0;
                    r_hash_out  <= (r_m == '0) ? r_h[23:0] : r_hmod[23:0];
                    r_valid_res <= (r_m != '0) && (r_acc == r_hmod);
                end else begin
                    r_sig_out   <= r_acc[23:0];
                    r_mod_out   <= r_m[23:0];
                    r_hash_out  <= r_h[23:0];
                    r_valid_res <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Status to the controller
    always_comb begin
        o_sts.div_busy  = w_busy;
        o_sts.rem_zero  = (w_rem == '0);
        o_sts.ksq_gt_x  = (r_ksq > {1'b0, r_x});
        o_sts.nr_zero   = (r_nr == '0);
        o_sts.e_zero    = (r_e == '0);
        o_sts.e_lsb     = r_e[0];
        o_sts.hash_last = (r_hi == r_hlast);
        o_sts.is_verify = (r_cmdv == trsa_pkg::CMD_VERIFY);
        o_sts.m_zero    = (r_m == '0);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid     = r_out_valid;
    assign o_signature_out = r_sig_out;
    assign o_modulus_out   = r_mod_out;
    assign o_hash_out      = r_hash_out;
    assign o_valid_res     = r_valid_res;
endmodule
`default_nettype wire

// ===== design/trsa_ctrl.sv =====
// Controller state machine sequencing hash, key derivation and exponentiation
`default_nettype none
module trsa_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire trsa_pkg::t_sts  i_sts,
    output trsa_pkg::t_cmd       o_cmd
);
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_HASH   = 5'd1;
    localparam logic [4:0] S_PSEED  = 5'd2;
    localparam logic [4:0] S_PTEST  = 5'd3;
    localparam logic [4:0] S_PDIV   = 5'd4;
    localparam logic [4:0] S_PFOUND = 5'd5;
    localparam logic [4:0] S_MULN   = 5'd6;
    localparam logic [4:0] S_EINIT  = 5'd7;
    localparam logic [4:0] S_ELOOP  = 5'd8;
    localparam logic [4:0] S_EDIV   = 5'd9;
    localparam logic [4:0] S_EUPD   = 5'd10;
    localparam logic [4:0] S_DFIN   = 5'd11;
    localparam logic [4:0] S_HDIV   = 5'd12;
    localparam logic [4:0] S_HWAIT  = 5'd13;
    localparam logic [4:0] S_VSIG   = 5'd14;
    localparam logic [4:0] S_SWAIT  = 5'd15;
    localparam logic [4:0] S_PLOOP  = 5'd16;
    localparam logic [4:0] S_PMD1   = 5'd17;
    localparam logic [4:0] S_PMW1   = 5'd18;
    localparam logic [4:0] S_PSQ    = 5'd19;
    localparam logic [4:0] S_PMD2   = 5'd20;
    localparam logic [4:0] S_PMW2   = 5'd21;
    localparam logic [4:0] S_DONE   = 5'd22;

    logic [4:0] r_state;
    logic [4:0] n_state;
    logic       r_qsel;
    logic       n_qsel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_qsel  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_qsel  <= n_qsel;
        end
    end

    // Next state and datapath command
    always_comb begin
        n_state    = r_state;
        n_qsel     = r_qsel;
        o_cmd.op   = trsa_pkg::OP_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = trsa_pkg::OP_LOAD;
                    n_state  = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.op = trsa_pkg::OP_HASH;
                if (i_sts.hash_last) begin
                    if (!i_sts.is_verify) begin
                        n_qsel  = 1'b0;
                        n_state = S_PSEED;
                    end else if (i_sts.m_zero) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_HDIV;
                    end
                end
            end
            S_PSEED: begin
                o_cmd.op = r_qsel ? trsa_pkg::OP_XSEED_Q : trsa_pkg::OP_XSEED_P;
                n_state  = S_PTEST;
            end
            S_PTEST: begin
                if (i_sts.ksq_gt_x) begin
                    n_state = S_PFOUND;
                end else begin
                    o_cmd.op = trsa_pkg::OP_DIV_XK;
                    n_state  = S_PDIV;
                end
            end
            S_PDIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = i_sts.rem_zero ? trsa_pkg::OP_XNEXT : trsa_pkg::OP_KNEXT;
                    n_state  = S_PTEST;
                end
            end
            S_PFOUND: begin
                if (r_qsel) begin
                    o_cmd.op = trsa_pkg::OP_SETQ;
                    n_state  = S_MULN;
                end else begin
                    o_cmd.op = trsa_pkg::OP_SETP;
                    n_qsel   = 1'b1;
                    n_state  = S_PSEED;
                end
            end
            S_MULN: begin
                o_cmd.op = trsa_pkg::OP_MUL_N;
                n_state  = S_EINIT;
            end
            S_EINIT: begin
                o_cmd.op = trsa_pkg::OP_EUC_INIT;
                n_state  = S_ELOOP;
            end
            S_ELOOP: begin
                if (i_sts.nr_zero) begin
                    n_state = S_DFIN;
                end else begin
                    o_cmd.op = trsa_pkg::OP_DIV_EUC;
                    n_state  = S_EDIV;
                end
            end
            S_EDIV: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = trsa_pkg::OP_EUC_MUL;
                    n_state  = S_EUPD;
                end
            end
            S_EUPD: begin
                o_cmd.op = trsa_pkg::OP_EUC_UPD;
                n_state  = S_ELOOP;
            end
            S_DFIN: begin
                o_cmd.op = trsa_pkg::OP_D_FIN;
                n_state  = S_HDIV;
            end
            S_HDIV: begin
                o_cmd.op = trsa_pkg::OP_DIV_HM;
                n_state  = S_HWAIT;
            end
            S_HWAIT: begin
                if (!i_sts.div_busy) begin
                    if (i_sts.is_verify) begin
                        o_cmd.op = trsa_pkg::OP_SET_HMOD;
                        n_state  = S_VSIG;
                    end else begin
                        o_cmd.op = trsa_pkg::OP_POW_INIT;
                        n_state  = S_PLOOP;
                    end
                end
            end
            S_VSIG: begin
                o_cmd.op = trsa_pkg::OP_DIV_SIG;
                n_state  = S_SWAIT;
            end
            S_SWAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = trsa_pkg::OP_POW_INIT;
                    n_state  = S_PLOOP;
                end
            end
            S_PLOOP: begin
                if (i_sts.e_zero) begin
                    n_state = S_DONE;
                end else if (i_sts.e_lsb) begin
                    o_cmd.op = trsa_pkg::OP_MUL_AB;
                    n_state  = S_PMD1;
                end else begin
                    n_state = S_PSQ;
                end
            end
            S_PMD1: begin
                o_cmd.op = trsa_pkg::OP_DIV_PROD;
                n_state  = S_PMW1;
            end
            S_PMW1: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = trsa_pkg::OP_SET_ACC;
                    n_state  = S_PSQ;
                end
            end
            S_PSQ: begin
                o_cmd.op = trsa_pkg::OP_MUL_BB;
                n_state  = S_PMD2;
            end
            S_PMD2: begin
                o_cmd.op = trsa_pkg::OP_DIV_PROD;
                n_state  = S_PMW2;
            end
            S_PMW2: begin
                if (!i_sts.div_busy) begin
                    o_cmd.op = trsa_pkg::OP_SET_BASE;
                    n_state  = S_PLOOP;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.op = trsa_pkg::OP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_HASH))
        else $error("accepted transaction did not start hashing");
    a_result_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == trsa_pkg::OP_RESULT) |-> i_sts.out_free)
        else $error("result written over an untaken result");
    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !i_sts.div_busy)
        else $error("ready raised while divider busy");
`endif
endmodule
`default_nettype wire

// ===== design/toy_rsa24_sign_verify.sv =====
// Sign time is set by the trial-division prime search
//   (13-bit dividends), extended Euclid (25-bit dividends) and up to 32 square-and-multiply
//   rounds (50-bit dividends) on one serial divider.
// Verify runs two 24-bit reductions and five exponent rounds; modulus 0 skips them.
// Throughput: one transaction at a time; the next is accepted while a result waits.
// Reset: synchronous active low; clears the controller, divider, output valid and config.
`default_nettype none
module toy_rsa24_sign_verify #(
    parameter int MESSAGE_BYTES = trsa_pkg::MESSAGE_BYTES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    trsa_in_if.sink     i_in,
    trsa_out_if.source  o_out,
    trsa_cfg_if.sink    i_cfg
);
    trsa_pkg::t_cmd w_cmd;
    trsa_pkg::t_sts w_sts;
    logic           w_in_ready;

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    trsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    trsa_dp #(.MESSAGE_BYTES(MESSAGE_BYTES)) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts),
        .i_in_cmd         (i_in.cmd),
        .i_in_message     (i_in.message),
        .i_in_modulus     (i_in.modulus),
        .i_in_signature   (i_in.signature),
        .i_cfg_we         (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_signature_out  (o_out.signature_out),
        .o_modulus_out    (o_out.modulus_out),
        .o_hash_out       (o_out.hash_out),
        .o_valid_res      (o_out.valid_res)
    );
endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the toy RSA sign/verify block: a self-checking predictor with directed and random traffic
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam logic [23:0] MASK24 = 24'hFFFFFF;

    typedef struct {
        logic        cmd;
        logic [39:0] message;
        logic [23:0] modulus;
        logic [23:0] signature;
    } t_req;

    typedef struct {
        logic [23:0] signature_out;
        logic [23:0] modulus_out;
        logic [23:0] hash_out;
        logic        valid_res;
    } t_res;

    // Predicts each result from the register copy and checks it in order
    class rsa_scoreboard;
        logic [15:0] key;
        logic [23:0] seed;
        t_res        pending[$];
        int          errors;

        function new();
            key = '0;
            seed = '0;
            errors = 0;
        endfunction

        function logic [23:0] mix_hash(logic [39:0] msg, logic [23:0] tail, int ntail);
            logic [31:0] h;
            logic [7:0]  b;
            h = {8'd0, seed};
            for (int i = 0; i < 5 + ntail; i++) begin
                if (i < 5) b = msg[8*(4-i) +: 8];
                else b = tail[8*(ntail-1-(i-5)) +: 8];
                h = h ^ (32'(b) + 32'(i) * 32'(trsa_pkg::HASH_STEP));
                h = {h[26:0], h[31:27]};
            end
            return h[23:0];
        endfunction

        function bit check_prime(int unsigned x);
            if (x < 2) return 0;
            for (int unsigned k = 2; k * k <= x; k++)
                if (x % k == 0) return 0;
            return 1;
        endfunction

        function int unsigned prime_from(int unsigned x);
            while (!check_prime(x)) x++;
            return x;
        endfunction

        function int unsigned inverse_of_e(int unsigned phi);
            longint t, nt, r, nr, qt, tmp;
            t = 0; nt = 1; r = phi; nr = trsa_pkg::PUB_EXP;
            while (nr != 0) begin
                qt = r / nr;
                tmp = nt; nt = t - qt * nt; t = tmp;
                tmp = nr; nr = r - qt * nr; r = tmp;
            end
            if (r > 1) return 32'hFFFFFFFF;
            if (t < 0) t += phi;
            return int'(t);
        endfunction

        function int unsigned mod_pow(int unsigned b, int unsigned e, int unsigned m);
            longint unsigned acc, base;
            acc = 1 % m;
            base = b % m;
            while (e != 0) begin
                if (e[0]) acc = (acc * base) % m;
                base = (base * base) % m;
                e >>= 1;
            end
            return int'(acc);
        endfunction

        // Derive modulus and private exponent from a private key
        function void key_pair(logic [15:0] k, output int unsigned n, output int unsigned d);
            int unsigned p, q;
            p = prime_from(32'((k >> 4) & 16'h0FFF) | 32'h800);
            q = prime_from(32'(k & 16'h0FFF) | 32'h800);
            n = p * q;
            d = inverse_of_e((p - 1) * (q - 1));
        endfunction

        function t_res predict(t_req r);
            t_res        res;
            int unsigned n, d, h;
            if (r.cmd == trsa_pkg::CMD_SIGN) begin
                key_pair(key, n, d);
                h = mix_hash(r.message, {8'd0, key}, 2);
                res.signature_out = 24'(mod_pow(h % n, d, n));
                res.modulus_out   = 24'(n);
                res.hash_out      = 24'(h);
                res.valid_res     = 1'b0;
            end else begin
                n = r.modulus;
                h = mix_hash(r.message, r.modulus, 3);
                res.signature_out = '0;
                res.modulus_out   = '0;
                if (n == 0) begin
                    res.hash_out  = 24'(h);
                    res.valid_res = 1'b0;
                end else begin
                    res.hash_out  = 24'(h % n);
                    res.valid_res = (mod_pow(r.signature, trsa_pkg::PUB_EXP, n) == h % n);
                end
            end
            return res;
        endfunction

        function void note_request(t_req r);
            pending.push_back(predict(r));
        endfunction

        function void check_result(t_res got);
            t_res exp;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("ERROR: unexpected result sig=%h n=%h hash=%h ok=%b",
                                           got.signature_out, got.modulus_out,
                                           got.hash_out, got.valid_res);
                return;
            end
            exp = pending.pop_front();
            if (got.signature_out !== exp.signature_out || got.modulus_out !== exp.modulus_out
                || got.hash_out !== exp.hash_out || got.valid_res !== exp.valid_res) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: exp sig=%h n=%h hash=%h ok=%b got sig=%h n=%h hash=%h ok=%b",
                             exp.signature_out, exp.modulus_out, exp.hash_out, exp.valid_res,
                             got.signature_out, got.modulus_out, got.hash_out, got.valid_res);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    trsa_in_if  in_ch ();
    trsa_out_if out_ch ();
    trsa_cfg_if cfg_ch ();

    toy_rsa24_sign_verify DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    rsa_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    always #2 i_clk = ~i_clk;

    initial begin
        in_ch.valid = 1'b0;
        in_ch.cmd = trsa_pkg::CMD_SIGN;
        in_ch.message = '0;
        in_ch.modulus = '0;
        in_ch.signature = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = trsa_pkg::REG_PRIVATE_KEY;
        cfg_ch.data = '0;
    end

    // Check results, stall the receiver and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                sb.check_result('{out_ch.signature_out, out_ch.modulus_out,
                                  out_ch.hash_out, out_ch.valid_res});
                quiet_cycles <= 0;
            end else if (!(in_ch.valid && in_ch.ready) && !(cfg_ch.valid && cfg_ch.ready)) begin
                quiet_cycles <= quiet_cycles + 1;
            end else begin
                quiet_cycles <= 0;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(logic idx, logic [23:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == trsa_pkg::REG_PRIVATE_KEY) sb.key = value[15:0];
        else sb.seed = value;
    endtask

    task automatic send_request(t_req r);
        if ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= r.cmd;
        in_ch.message   <= r.message;
        in_ch.modulus   <= r.modulus;
        in_ch.signature <= r.signature;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_request(r);
    endtask

    // Hold off until every result is back, then let the block settle
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic logic [39:0] rand_msg();
        return {8'($urandom), $urandom};
    endfunction

    // Verify built to pass under the current key, when the modulus fits and the private exponent exists
    function automatic t_req signed_verify(logic [39:0] msg);
        t_req        r;
        int unsigned n, d, h;
        sb.key_pair(sb.key, n, d);
        r.cmd = trsa_pkg::CMD_VERIFY;
        r.message = msg;
        r.modulus = 24'(n);
        h = sb.mix_hash(msg, r.modulus, 3);
        if (n <= MASK24 && d != 32'hFFFFFFFF) r.signature = 24'(sb.mod_pow(h % n, d, n));
        else r.signature = 24'($urandom);
        return r;
    endfunction

    function automatic t_req random_request();
        t_req r;
        int   pick;
        pick = $urandom_range(99);
        r = '{trsa_pkg::CMD_SIGN, rand_msg(), 24'($urandom), 24'($urandom)};
        if (pick < 35) return r;
        if (pick < 75) return signed_verify(r.message);
        r.cmd = trsa_pkg::CMD_VERIFY;
        if (pick < 82) r.modulus = '0;
        else if (pick < 90) begin
            r = signed_verify(r.message);
            r.signature[$urandom_range(23)] ^= 1'b1;
        end
        return r;
    endfunction

    initial begin
        int unsigned n, d;
        logic [15:0] odd_key;
        logic [15:0] keys[4];
        logic [23:0] seeds[4];

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, both commands, degenerate cases
        send_request('{trsa_pkg::CMD_SIGN, 40'd0, 24'd0, 24'd0});
        send_request('{trsa_pkg::CMD_SIGN, '1, '1, '1});
        send_request('{trsa_pkg::CMD_VERIFY, '1, 24'd0, '1});
        send_request('{trsa_pkg::CMD_VERIFY, 40'd0, 24'd0, 24'd0});
        send_request('{trsa_pkg::CMD_VERIFY, '1, '1, '1});
        send_request('{trsa_pkg::CMD_VERIFY, 40'h0123456789, 24'd7, 24'hFFFFFF});
        send_request('{trsa_pkg::CMD_VERIFY, 40'd0, 24'd1, 24'd0});
        send_request(signed_verify(40'hA5A5A5A5A5));
        drain();

        // Find a key for which 17 divides phi, so no inverse exists
        odd_key = 16'($urandom);
        do begin
            odd_key++;
            sb.key_pair(odd_key, n, d);
        end while (d != 32'hFFFFFFFF);
        write_reg(trsa_pkg::REG_PRIVATE_KEY, {8'd0, odd_key});
        write_reg(trsa_pkg::REG_HASH_SEED, 24'h5A5A5A);
        send_request('{trsa_pkg::CMD_SIGN, rand_msg(), 24'd0, 24'd0});
        send_request(signed_verify(rand_msg()));
        drain();

        write_reg(trsa_pkg::REG_PRIVATE_KEY, 24'h00FFFF);
        write_reg(trsa_pkg::REG_HASH_SEED, MASK24);
        send_request('{trsa_pkg::CMD_SIGN, '1, 24'd0, 24'd0});
        send_request(signed_verify('1));
        drain();

        // Random phases, one idling style each
        keys  = '{16'($urandom), 16'h0000, 16'($urandom), 16'hFFFF};
        seeds = '{24'($urandom), 24'h000000, 24'($urandom), MASK24};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(trsa_pkg::REG_PRIVATE_KEY, {8'd0, keys[ph]});
            write_reg(trsa_pkg::REG_HASH_SEED, seeds[ph]);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            for (int i = 0; i < 25; i++) send_request(random_request());
            drain();
        end

        if (sb.errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
